@@ src/pwsh_pkg.sv @@
// Shared types and constants for the prime-weighted string hash.
// Holds the prime weight table and the divider status bundle; no dependencies.
`default_nettype none

package pwsh_pkg;

  // Widths fixed by the word layout.
  localparam int CHAR_W   = 8;
  localparam int HASH_W   = 32;
  localparam int POS_W    = 7;
  localparam int PRIME_W  = 13;
  localparam int BUCKET_W = 31;

  // Reset value of the bucket count register.
  localparam logic [BUCKET_W-1:0] BUCKET_RESET = 31'd500009;

  // Prime weight for each character position, position 0 first.
  localparam logic [PRIME_W-1:0] PRIME_TABLE [128] = '{
    13'd1009, 13'd1049, 13'd1093, 13'd1151, 13'd1201, 13'd1249, 13'd1297, 13'd1361,
    13'd1427, 13'd1459, 13'd1499, 13'd1559, 13'd1607, 13'd1657, 13'd1709, 13'd1759,
    13'd1823, 13'd1877, 13'd1933, 13'd1997, 13'd2039, 13'd2089, 13'd2141, 13'd2213,
    13'd2269, 13'd2311, 13'd2371, 13'd2411, 13'd2467, 13'd2543, 13'd2609, 13'd2663,
    13'd2699, 13'd2741, 13'd2797, 13'd2851, 13'd2909, 13'd2969, 13'd3037, 13'd3089,
    13'd3169, 13'd3221, 13'd3299, 13'd3331, 13'd3389, 13'd3461, 13'd3517, 13'd3557,
    13'd3613, 13'd3671, 13'd3719, 13'd3779, 13'd3847, 13'd3907, 13'd3943, 13'd4013,
    13'd4073, 13'd4129, 13'd4201, 13'd4243, 13'd4289, 13'd4363, 13'd4441, 13'd4493,
    13'd4549, 13'd4621, 13'd4663, 13'd4729, 13'd4793, 13'd4871, 13'd4933, 13'd4973,
    13'd5021, 13'd5087, 13'd5153, 13'd5227, 13'd5281, 13'd5351, 13'd5417, 13'd5471,
    13'd5519, 13'd5573, 13'd5651, 13'd5693, 13'd5749, 13'd5821, 13'd5861, 13'd5923,
    13'd6011, 13'd6073, 13'd6131, 13'd6199, 13'd6257, 13'd6301, 13'd6353, 13'd6397,
    13'd6481, 13'd6563, 13'd6619, 13'd6689, 13'd6737, 13'd6803, 13'd6863, 13'd6917,
    13'd6977, 13'd7027, 13'd7109, 13'd7187, 13'd7237, 13'd7309, 13'd7393, 13'd7477,
    13'd7523, 13'd7561, 13'd7607, 13'd7681, 13'd7727, 13'd7817, 13'd7877, 13'd7933,
    13'd8011, 13'd8039, 13'd8059, 13'd8081, 13'd8093, 13'd8111, 13'd8123, 13'd8147
  };

  // Status of the remainder unit as seen by the sequencer.
  typedef struct packed {
    logic busy;  // iterations in progress
    logic done;  // remainder valid, held until the next start
  } div_stat_t;

endpackage

`default_nettype wire

@@ src/pwsh_mod.sv @@
// Restoring remainder unit: 32-bit dividend modulo a 31-bit divisor, one bit per cycle.
// Depends on pwsh_pkg for widths and the status bundle.
`default_nettype none

module pwsh_mod
  import pwsh_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire logic [HASH_W-1:0]   dividend,
  input  wire logic [BUCKET_W-1:0] divisor,
  output div_stat_t                stat,
  output logic      [BUCKET_W-1:0] remainder
);

  logic                busy;
  logic                done;
  logic [4:0]          count;
  logic [HASH_W-1:0]   dividend_sh;
  logic [BUCKET_W-1:0] rem;
  logic [BUCKET_W-1:0] divisor_r;

  logic [HASH_W-1:0]   rem_shift;
  logic                fits;
  logic [BUCKET_W-1:0] rem_next;

  // One restoring step: bring in the next dividend bit, subtract if it fits.
  always_comb begin
    rem_shift = {rem, dividend_sh[HASH_W-1]};
    fits      = rem_shift >= {1'b0, divisor_r};
    if (fits) begin
      rem_next = BUCKET_W'(rem_shift - {1'b0, divisor_r});
    end else begin
      rem_next = rem_shift[BUCKET_W-1:0];
    end
  end

  // Sequencing of the 32 iterations.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      done  <= 1'b0;
      count <= 5'd31;
    end else if (busy) begin
      count <= count - 5'd1;
      if (count == 5'd0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (start) begin
      dividend_sh <= dividend;
      divisor_r   <= divisor;
      rem         <= '0;
    end else if (busy) begin
      dividend_sh <= {dividend_sh[HASH_W-2:0], 1'b0};
      rem         <= rem_next;
    end
  end

  assign stat = '{busy: busy, done: done};

  // A zero divisor gives a zero index.
  assign remainder = (divisor_r == '0) ? '0 : rem;

  a_not_busy_and_done : assert property (@(posedge clk) disable iff (rst)
    !(busy && done)) else $error("remainder unit busy and done together");

  a_start_busy : assert property (@(posedge clk) disable iff (rst)
    start |=> busy && !done) else $error("start did not launch the iterations");

  a_rem_bound : assert property (@(posedge clk) disable iff (rst)
    (busy || done) && !start |-> (rem < divisor_r) || (divisor_r == '0))
    else $error("partial remainder not below divisor");

endmodule

`default_nettype wire

@@ src/prime_weighted_string_hash.sv @@
// Top level of the prime-weighted string hash with bucket reduction.
// Depends on pwsh_pkg and the remainder unit pwsh_mod.
//
//   channel | direction | tdata (low bit up)          | tuser / tlast
//   s_*     | in        | character[7:0]              | tlast = last_char
//   m_*     | out       | bucket_index[30:0], 0 pad   | none
//   cfg_*   | in        | bucket_count[30:0]          | write enable, no read-back
//
// A character that is not the last is accepted, then the hash is updated: XOR at an
// even position, the 32x32 multiplier at an odd one. The last character also goes
// through the 32 iterations of the one-bit-per-cycle remainder unit and then into the
// output register; the load waits while that register still holds an unaccepted word.
// rst is synchronous and active high; it clears the hash, the position and the
// output valid flag, and loads bucket_count with 500009.
// The output register holds a finished word while the next name streams in; a
// new index waits in the remainder unit until that register is free.
`default_nettype none

module prime_weighted_string_hash
  import pwsh_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  input  wire logic [7:0]          s_tdata,    // [7:0] character
  input  wire logic                s_tlast,
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  output logic [31:0]              m_tdata,    // [30:0] bucket_index, [31] zero
  input  wire logic                cfg_wr_en,
  input  wire logic [BUCKET_W-1:0] cfg_wr_data // [30:0] bucket_count
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_MULT = 3'b010,
    ST_DIV  = 3'b100
  } state_t;

  state_t              state;
  state_t              state_next;
  logic [HASH_W-1:0]   running_hash;
  logic [HASH_W-1:0]   hash_next;
  logic [POS_W-1:0]    char_position;
  logic [HASH_W-1:0]   term;
  logic                last;
  logic [BUCKET_W-1:0] bucket_count;
  logic                out_valid;
  logic [BUCKET_W-1:0] out_data;

  logic                in_accept;
  logic                out_free;
  logic                out_load;
  logic                div_start;
  div_stat_t           div_stat;
  logic [BUCKET_W-1:0] div_rem;

  logic signed [21:0]  char_ext;
  logic signed [21:0]  prime_ext;
  logic signed [21:0]  weighted;

  assign s_tready  = (state == ST_IDLE);
  assign in_accept = s_tvalid && s_tready;
  assign out_free  = !out_valid || m_tready;
  assign out_load  = (state == ST_DIV) && div_stat.done && out_free;
  assign div_start = (state == ST_MULT) && last;

  // Weighted character: sign-extended character times the position's prime.
  always_comb begin
    char_ext  = 22'($signed(s_tdata));
    prime_ext = $signed(22'({1'b0, PRIME_TABLE[char_position]}));
    weighted  = char_ext * prime_ext;
  end

  // Hash update: XOR at an even position, multiply at an odd one.
  always_comb begin
    if (char_position[0]) begin
      hash_next = running_hash * term;
    end else begin
      hash_next = running_hash ^ term;
    end
  end

  // Sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_accept) state_next = ST_MULT;
      end
      ST_MULT: begin
        state_next = last ? ST_DIV : ST_IDLE;
      end
      ST_DIV: begin
        if (out_load) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control state: sequencer, hash and position.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      running_hash  <= '0;
      char_position <= '0;
    end else begin
      state <= state_next;
      if (state == ST_MULT) begin
        running_hash  <= hash_next;
        char_position <= char_position + POS_W'(1);
      end else if (out_load) begin
        running_hash  <= '0;
        char_position <= '0;
      end
    end
  end

  // Captured input word.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      term <= HASH_W'(weighted);
      last <= s_tlast;
    end
  end

  // Bucket count register.
  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_count <= BUCKET_RESET;
    end else if (cfg_wr_en) begin
      bucket_count <= cfg_wr_data;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= div_rem;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {1'b0, out_data};

  pwsh_mod u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (hash_next),
    .divisor   (bucket_count),
    .stat      (div_stat),
    .remainder (div_rem)
  );

  a_accept_to_mult : assert property (@(posedge clk) disable iff (rst)
    in_accept |=> state == ST_MULT) else $error("accepted word did not reach the multiply step");

  a_load_when_free : assert property (@(posedge clk) disable iff (rst)
    out_load |-> !m_tvalid || m_tready) else $error("output word overwritten");

  a_clear_after_load : assert property (@(posedge clk) disable iff (rst)
    out_load |=> running_hash == '0 && char_position == '0 && m_tvalid)
    else $error("state not cleared after the last character");

  a_div_only_in_div : assert property (@(posedge clk) disable iff (rst)
    div_stat.busy |-> state == ST_DIV) else $error("remainder unit running outside its step");

endmodule

`default_nettype wire
